// ----- sv/ctc_pkg.sv -----
// Types, codes and helper functions shared by the C token classifier modules.
package ctc_pkg;

    localparam int DEF_MAX_IDENTS   = 64;
    localparam int DEF_MAX_NAME_LEN = 16;
    localparam int DEF_MAX_DEPTH    = 255;

    localparam int NUM_KW  = 32;
    localparam int KW_LEN  = 8;
    localparam int NUM_CLS = 7;

    localparam logic [2:0] CLS_ARITH   = 3'd0;
    localparam logic [2:0] CLS_CONST   = 3'd1;
    localparam logic [2:0] CLS_BRACKET = 3'd2;
    localparam logic [2:0] CLS_LOGIC   = 3'd3;
    localparam logic [2:0] CLS_KW      = 3'd4;
    localparam logic [2:0] CLS_IDENT   = 3'd5;
    localparam logic [2:0] CLS_SEMI    = 3'd6;

    localparam logic [3:0] LG_GT  = 4'd0;
    localparam logic [3:0] LG_LT  = 4'd1;
    localparam logic [3:0] LG_NOT = 4'd2;
    localparam logic [3:0] LG_GE  = 4'd3;
    localparam logic [3:0] LG_LE  = 4'd4;
    localparam logic [3:0] LG_NE  = 4'd5;
    localparam logic [3:0] LG_EQ  = 4'd6;
    localparam logic [3:0] LG_INC = 4'd7;
    localparam logic [3:0] LG_DEC = 4'd8;
    localparam logic [3:0] LG_AND = 4'd9;
    localparam logic [3:0] LG_OR  = 4'd10;

    localparam logic [1:0] BR_PAREN = 2'd0;
    localparam logic [1:0] BR_BRACE = 2'd1;
    localparam logic [1:0] BR_SQUARE = 2'd2;

    localparam logic [7:0] FULL_CODE = 8'hFF;
    localparam logic [7:0] CNT_MAX   = 8'hFF;

    typedef enum logic [1:0] {
        PK_NONE,
        PK_OP,
        PK_NUM,
        PK_NAME
    } t_pkind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEND,
        ST_KW,
        ST_SRCH,
        ST_NEW,
        ST_EOL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  token_class;
        logic [7:0]  token_code;
        logic [31:0] const_value;
        logic        first_seen;
        logic [7:0]  class_count;
        logic        overflow;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic        req;
        logic [2:0]  cls;
        logic [7:0]  code;
        logic [31:0] val;
        logic        first;
        logic        ovf;
        logic        bump;
    } t_emit;

    typedef struct packed {
        logic active;
        logic found;
        logic placed;
    } t_probe;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic [2:0] op_bit(input logic [7:0] c);
        logic [2:0] b;
        unique case (c)
            "*":     b = 3'd0;
            "/":     b = 3'd1;
            "%":     b = 3'd2;
            "=":     b = 3'd3;
            "+":     b = 3'd4;
            "-":     b = 3'd5;
            default: b = 3'd6;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] bracket_kind(input logic [7:0] c);
        logic [1:0] k;
        unique case (c)
            "(", ")": k = BR_PAREN;
            "{", "}": k = BR_BRACE;
            default:  k = BR_SQUARE;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] combine(input logic [7:0] p, input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c == "=") begin
            if (p == ">") r = {1'b1, LG_GE};
            if (p == "<") r = {1'b1, LG_LE};
            if (p == "!") r = {1'b1, LG_NE};
            if (p == "=") r = {1'b1, LG_EQ};
        end else if (c == p) begin
            if (p == "+") r = {1'b1, LG_INC};
            if (p == "-") r = {1'b1, LG_DEC};
            if (p == "&") r = {1'b1, LG_AND};
            if (p == "|") r = {1'b1, LG_OR};
        end
        return r;
    endfunction

    function automatic t_emit mk_emit(input logic [2:0] cls, input logic [7:0] code,
                                      input logic [31:0] val, input logic first,
                                      input logic ovf, input logic bump);
        t_emit e;
        e.req   = 1'b1;
        e.cls   = cls;
        e.code  = code;
        e.val   = val;
        e.first = first;
        e.ovf   = ovf;
        e.bump  = bump;
        return e;
    endfunction

    function automatic t_emit mk_seen(input logic [2:0] cls, input logic [7:0] c,
                                      input logic [6:0] seen);
        logic first;
        first = !seen[op_bit(c)];
        return mk_emit(cls, c, 32'd0, first, 1'b0, first);
    endfunction

    function automatic t_emit mk_logic(input logic [3:0] code);
        return mk_emit(CLS_LOGIC, 8'(code), 32'd0, 1'b0, 1'b0, 1'b1);
    endfunction

    function automatic t_emit fin_op(input logic [7:0] p, input logic [6:0] seen);
        t_emit e;
        e = '0;
        if (p == ">") e = mk_logic(LG_GT);
        else if (p == "<") e = mk_logic(LG_LT);
        else if (p == "!") e = mk_logic(LG_NOT);
        else if (p == "=" || p == "+" || p == "-") e = mk_seen(CLS_ARITH, p, seen);
        return e;
    endfunction

    function automatic t_emit fin_num(input logic [31:0] acc, input logic spoil);
        t_emit e;
        e = '0;
        if (!spoil) e = mk_emit(CLS_CONST, 8'd0, acc, 1'b0, 1'b0, 1'b1);
        return e;
    endfunction

    function automatic logic [63:0] kw_word(input logic [4:0] k);
        logic [63:0] w;
        unique case (k)
            5'd0:  w = {"auto", 32'h0};
            5'd1:  w = {"double", 16'h0};
            5'd2:  w = {"int", 40'h0};
            5'd3:  w = {"struct", 16'h0};
            5'd4:  w = {"const", 24'h0};
            5'd5:  w = {"float", 24'h0};
            5'd6:  w = {"short", 24'h0};
            5'd7:  w = "unsigned";
            5'd8:  w = {"break", 24'h0};
            5'd9:  w = {"else", 32'h0};
            5'd10: w = {"long", 32'h0};
            5'd11: w = {"switch", 16'h0};
            5'd12: w = "continue";
            5'd13: w = {"for", 40'h0};
            5'd14: w = {"signed", 16'h0};
            5'd15: w = {"void", 32'h0};
            5'd16: w = {"case", 32'h0};
            5'd17: w = {"enum", 32'h0};
            5'd18: w = "register";
            5'd19: w = {"typedef", 8'h0};
            5'd20: w = {"default", 8'h0};
            5'd21: w = {"goto", 32'h0};
            5'd22: w = {"sizeof", 16'h0};
            5'd23: w = "volatile";
            5'd24: w = {"char", 32'h0};
            5'd25: w = {"extern", 16'h0};
            5'd26: w = {"return", 16'h0};
            5'd27: w = {"union", 24'h0};
            5'd28: w = {"do", 48'h0};
            5'd29: w = {"if", 48'h0};
            5'd30: w = {"static", 16'h0};
            default: w = {"while", 24'h0};
        endcase
        return w;
    endfunction

endpackage

// ----- sv/ctc_cell.sv -----
// One identifier table cell: holds one entry and passes the search probe to its neighbor.
module ctc_cell #(
    parameter int SLOT         = 0,
    parameter int MAX_IDENTS   = ctc_pkg::DEF_MAX_IDENTS,
    parameter int MAX_NAME_LEN = ctc_pkg::DEF_MAX_NAME_LEN,
    localparam int NAME_W = 8 * MAX_NAME_LEN,
    localparam int SLOT_W = (MAX_IDENTS > 1) ? $clog2(MAX_IDENTS) : 1,
    localparam int CNT_W  = $clog2(MAX_IDENTS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CNT_W-1:0]     i_count,
    input  ctc_pkg::t_probe      i_probe,
    input  logic [NAME_W-1:0]    i_name,
    input  logic [SLOT_W-1:0]    i_slot,
    output ctc_pkg::t_probe      o_probe,
    output logic [NAME_W-1:0]    o_name,
    output logic [SLOT_W-1:0]    o_slot
);

    logic [NAME_W-1:0] r_entry;
    logic [NAME_W-1:0] n_entry;
    ctc_pkg::t_probe   r_probe;
    ctc_pkg::t_probe   n_probe;
    logic [NAME_W-1:0] r_name;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              w_open;

    assign w_open = i_probe.active && !i_probe.found && !i_probe.placed;

    always_comb begin
        n_entry = r_entry;
        n_probe = i_probe;
        n_slot  = i_slot;
        if (w_open) begin
            if ((CNT_W'(SLOT) < i_count) && (r_entry == i_name)) begin
                n_probe.found = 1'b1;
                n_slot        = SLOT_W'(SLOT);
            end else if (CNT_W'(SLOT) == i_count) begin
                n_entry        = i_name;
                n_probe.placed = 1'b1;
                n_slot         = SLOT_W'(SLOT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
        r_entry <= n_entry;
        r_name  <= i_name;
        r_slot  <= n_slot;
    end

    assign o_probe = r_probe;
    assign o_name  = r_name;
    assign o_slot  = r_slot;

endmodule

// ----- sv/c_token_classifier_top.sv -----
// Top level of the C token classifier: lexer sequencer, counters and identifier cell chain.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+-------------------------
//   in      | i_in_valid  | o_in_ready  | i_in_data  (t_in_item)
//   out     | o_out_valid | i_out_ready | o_out_data (t_out_item)
//
// An item passes through the steps accept, pending token, new character, end of line, release.
// A name that is no keyword adds a keyword check and a search of the identifier cell chain,
// which the probe walks one cell per cycle; a keyword adds only the keyword check.
// Reset is synchronous; the identifier table and name buffer need no clearing.
// A stalled output holds the sequencer whenever a result waits in the hold register.
module c_token_classifier_top #(
    parameter int MAX_IDENTS   = ctc_pkg::DEF_MAX_IDENTS,
    parameter int MAX_NAME_LEN = ctc_pkg::DEF_MAX_NAME_LEN,
    parameter int MAX_DEPTH    = ctc_pkg::DEF_MAX_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ctc_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ctc_pkg::t_out_item   o_out_data
);

    localparam int NAME_W = 8 * MAX_NAME_LEN;
    localparam int SLOT_W = (MAX_IDENTS > 1) ? $clog2(MAX_IDENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_IDENTS + 1);
    localparam int LEN_W  = $clog2(MAX_NAME_LEN + 2);
    localparam int IDX_W  = $clog2(MAX_NAME_LEN);
    localparam int DEP_W  = $clog2(MAX_DEPTH + 1);

    ctc_pkg::t_state    r_state, n_state;
    logic [7:0]         r_char, n_char;
    logic               r_eol, n_eol;
    logic               r_used, n_used;
    logic               r_ret_eol, n_ret_eol;
    ctc_pkg::t_pkind    r_pkind, n_pkind;
    logic [7:0]         r_pop, n_pop;
    logic [7:0]         r_nbuf [MAX_NAME_LEN];
    logic [7:0]         n_nbuf [MAX_NAME_LEN];
    logic [LEN_W-1:0]   r_nlen, n_nlen;
    logic [31:0]        r_acc, n_acc;
    logic               r_spoil, n_spoil;
    logic [DEP_W-1:0]   r_depth [3];
    logic [DEP_W-1:0]   n_depth [3];
    logic [31:0]        r_kw_seen, n_kw_seen;
    logic [6:0]         r_op_seen, n_op_seen;
    logic [CNT_W-1:0]   r_icnt, n_icnt;
    logic [7:0]         r_ccnt [ctc_pkg::NUM_CLS];
    logic [7:0]         n_ccnt [ctc_pkg::NUM_CLS];
    logic               r_res_v, n_res_v;
    ctc_pkg::t_probe    r_res, n_res;
    logic [SLOT_W-1:0]  r_res_slot, n_res_slot;
    logic               r_hold_v, n_hold_v;
    ctc_pkg::t_out_item r_hold, n_hold;
    logic               r_out_v, n_out_v;
    ctc_pkg::t_out_item r_out, n_out;

    ctc_pkg::t_emit     w_e;
    ctc_pkg::t_probe    w_pc [MAX_IDENTS+1];
    logic [NAME_W-1:0]  w_pn [MAX_IDENTS+1];
    logic [SLOT_W-1:0]  w_ps [MAX_IDENTS+1];
    logic [NAME_W-1:0]  w_name_flat;
    logic [63:0]        w_name_be;
    logic               w_kw_hit;
    logic [4:0]         w_kw_idx;
    logic               w_launch;
    logic               w_out_free;
    logic               w_go;
    logic               w_novf;
    logic [35:0]        w_acc_mul;
    logic [31:0]        w_acc_sat;
    logic [4:0]         w_cmb;
    logic [1:0]         w_bk;
    logic [7:0]         w_cnt_new;

    always_comb begin
        for (int i = 0; i < MAX_NAME_LEN; i++) begin
            w_name_flat[8*i +: 8] = r_nbuf[i];
        end
        for (int i = 0; i < ctc_pkg::KW_LEN; i++) begin
            w_name_be[63-8*i -: 8] = r_nbuf[i];
        end
    end

    always_comb begin
        w_kw_hit = 1'b0;
        w_kw_idx = '0;
        for (int k = ctc_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (w_name_be == ctc_pkg::kw_word(5'(k))) begin
                w_kw_hit = 1'b1;
                w_kw_idx = 5'(k);
            end
        end
        if (r_nlen > LEN_W'(ctc_pkg::KW_LEN)) w_kw_hit = 1'b0;
    end

    assign w_novf     = r_nlen > LEN_W'(MAX_NAME_LEN);
    assign w_out_free = !r_out_v || i_out_ready;
    assign w_go       = !r_hold_v || w_out_free;
    assign w_acc_mul  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + 36'(r_char - "0");
    assign w_acc_sat  = (|w_acc_mul[35:32]) ? 32'hFFFF_FFFF : w_acc_mul[31:0];
    assign w_cmb      = ctc_pkg::combine(r_pop, r_char);
    assign w_bk       = ctc_pkg::bracket_kind(r_char);
    assign w_launch   = (r_state == ctc_pkg::ST_KW) && w_go && !w_kw_hit;

    assign w_pc[0] = '{active: w_launch, found: 1'b0, placed: 1'b0};
    assign w_pn[0] = w_name_flat;
    assign w_ps[0] = '0;

    for (genvar g = 0; g < MAX_IDENTS; g++) begin : g_cell
        ctc_cell #(
            .SLOT         (g),
            .MAX_IDENTS   (MAX_IDENTS),
            .MAX_NAME_LEN (MAX_NAME_LEN)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_icnt),
            .i_probe (w_pc[g]),
            .i_name  (w_pn[g]),
            .i_slot  (w_ps[g]),
            .o_probe (w_pc[g+1]),
            .o_name  (w_pn[g+1]),
            .o_slot  (w_ps[g+1])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_char    = r_char;
        n_eol     = r_eol;
        n_used    = r_used;
        n_ret_eol = r_ret_eol;
        n_pkind   = r_pkind;
        n_pop     = r_pop;
        n_nbuf    = r_nbuf;
        n_nlen    = r_nlen;
        n_acc     = r_acc;
        n_spoil   = r_spoil;
        n_depth   = r_depth;
        n_kw_seen = r_kw_seen;
        n_op_seen = r_op_seen;
        n_icnt    = r_icnt;
        n_ccnt    = r_ccnt;
        n_res_v   = r_res_v;
        n_res     = r_res;
        n_res_slot = r_res_slot;
        n_hold_v  = r_hold_v;
        n_hold    = r_hold;
        n_out_v   = r_out_v;
        n_out     = r_out;
        w_e       = '0;
        w_cnt_new = '0;
        o_in_ready = 1'b0;

        if (i_out_ready) n_out_v = 1'b0;

        if (w_pc[MAX_IDENTS].active) begin
            n_res_v    = 1'b1;
            n_res      = w_pc[MAX_IDENTS];
            n_res_slot = w_ps[MAX_IDENTS];
        end

        unique case (r_state)
            ctc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_char  = i_in_data.char_code;
                    n_eol   = i_in_data.end_of_line;
                    n_used  = 1'b0;
                    n_state = ctc_pkg::ST_PEND;
                end
            end
            ctc_pkg::ST_PEND: begin
                if (w_go) begin
                    n_state = ctc_pkg::ST_NEW;
                    unique case (r_pkind)
                        ctc_pkg::PK_OP: begin
                            n_pkind = ctc_pkg::PK_NONE;
                            if (w_cmb[4]) begin
                                w_e    = ctc_pkg::mk_logic(w_cmb[3:0]);
                                n_used = 1'b1;
                            end else begin
                                w_e = ctc_pkg::fin_op(r_pop, r_op_seen);
                            end
                        end
                        ctc_pkg::PK_NUM: begin
                            if (ctc_pkg::is_digit(r_char)) begin
                                n_acc  = w_acc_sat;
                                n_used = 1'b1;
                            end else if (ctc_pkg::is_letter(r_char) || r_char == "_"
                                         || r_char == "-") begin
                                n_spoil = 1'b1;
                                n_used  = 1'b1;
                            end else begin
                                w_e     = ctc_pkg::fin_num(r_acc, r_spoil);
                                n_pkind = ctc_pkg::PK_NONE;
                                n_acc   = '0;
                                n_spoil = 1'b0;
                            end
                        end
                        ctc_pkg::PK_NAME: begin
                            if (ctc_pkg::is_letter(r_char) || ctc_pkg::is_digit(r_char)
                                || r_char == "_") begin
                                if (r_nlen < LEN_W'(MAX_NAME_LEN)) begin
                                    n_nbuf[r_nlen[IDX_W-1:0]] = r_char;
                                end
                                if (r_nlen <= LEN_W'(MAX_NAME_LEN)) n_nlen = r_nlen + 1'b1;
                                n_used = 1'b1;
                            end else begin
                                n_pkind   = ctc_pkg::PK_NONE;
                                n_ret_eol = 1'b0;
                                n_state   = ctc_pkg::ST_KW;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ctc_pkg::ST_KW: begin
                if (w_go) begin
                    if (w_kw_hit) begin
                        w_e = ctc_pkg::mk_emit(ctc_pkg::CLS_KW, 8'(w_kw_idx), 32'd0,
                                               !r_kw_seen[w_kw_idx], 1'b0,
                                               !r_kw_seen[w_kw_idx]);
                        n_nlen  = '0;
                        n_state = r_ret_eol ? ctc_pkg::ST_DONE : ctc_pkg::ST_NEW;
                    end else begin
                        n_state = ctc_pkg::ST_SRCH;
                    end
                end
            end
            ctc_pkg::ST_SRCH: begin
                if (w_go && r_res_v) begin
                    n_res_v = 1'b0;
                    if (r_res.found) begin
                        w_e = ctc_pkg::mk_emit(ctc_pkg::CLS_IDENT, 8'(r_res_slot), 32'd0,
                                               1'b0, w_novf, 1'b0);
                    end else if (r_res.placed) begin
                        w_e = ctc_pkg::mk_emit(ctc_pkg::CLS_IDENT, 8'(r_res_slot), 32'd0,
                                               1'b1, w_novf, 1'b1);
                    end else begin
                        w_e = ctc_pkg::mk_emit(ctc_pkg::CLS_IDENT, ctc_pkg::FULL_CODE,
                                               32'd0, 1'b0, 1'b1, 1'b0);
                    end
                    n_nlen  = '0;
                    n_state = r_ret_eol ? ctc_pkg::ST_DONE : ctc_pkg::ST_NEW;
                end
            end
            ctc_pkg::ST_NEW: begin
                if (w_go) begin
                    n_state = ctc_pkg::ST_EOL;
                    if (!r_used) begin
                        if (ctc_pkg::is_digit(r_char)) begin
                            n_pkind = ctc_pkg::PK_NUM;
                            n_acc   = 32'(r_char - "0");
                            n_spoil = 1'b0;
                        end else if (ctc_pkg::is_letter(r_char) || r_char == "_") begin
                            n_pkind = ctc_pkg::PK_NAME;
                            for (int i = 0; i < MAX_NAME_LEN; i++) n_nbuf[i] = 8'd0;
                            n_nbuf[0] = r_char;
                            n_nlen    = LEN_W'(1);
                        end else if (r_char == ";") begin
                            w_e = ctc_pkg::mk_seen(ctc_pkg::CLS_SEMI, r_char, r_op_seen);
                        end else if (r_char == "*" || r_char == "/" || r_char == "%") begin
                            w_e = ctc_pkg::mk_seen(ctc_pkg::CLS_ARITH, r_char, r_op_seen);
                        end else if (r_char == ">" || r_char == "<" || r_char == "!"
                                     || r_char == "=" || r_char == "+" || r_char == "-"
                                     || r_char == "&" || r_char == "|") begin
                            n_pkind = ctc_pkg::PK_OP;
                            n_pop   = r_char;
                        end else if (r_char == "(" || r_char == "{" || r_char == "[") begin
                            if (r_depth[w_bk] < DEP_W'(MAX_DEPTH)) begin
                                n_depth[w_bk] = r_depth[w_bk] + 1'b1;
                            end
                        end else if (r_char == ")" || r_char == "}" || r_char == "]") begin
                            if (r_depth[w_bk] != '0) begin
                                n_depth[w_bk] = r_depth[w_bk] - 1'b1;
                                w_e = ctc_pkg::mk_emit(ctc_pkg::CLS_BRACKET, 8'(w_bk), 32'd0,
                                                       1'b0, 1'b0, 1'b1);
                            end
                        end
                    end
                end
            end
            ctc_pkg::ST_EOL: begin
                if (w_go) begin
                    n_state = ctc_pkg::ST_DONE;
                    if (r_eol) begin
                        n_pkind = ctc_pkg::PK_NONE;
                        unique case (r_pkind)
                            ctc_pkg::PK_OP: begin
                                w_e = ctc_pkg::fin_op(r_pop, r_op_seen);
                            end
                            ctc_pkg::PK_NUM: begin
                                w_e     = ctc_pkg::fin_num(r_acc, r_spoil);
                                n_acc   = '0;
                                n_spoil = 1'b0;
                            end
                            ctc_pkg::PK_NAME: begin
                                n_ret_eol = 1'b1;
                                n_state   = ctc_pkg::ST_KW;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            ctc_pkg::ST_DONE: begin
                if (w_go) begin
                    if (r_hold_v) begin
                        n_out             = r_hold;
                        n_out.last_of_run = 1'b1;
                        n_out_v           = 1'b1;
                        n_hold_v          = 1'b0;
                    end
                    n_state = ctc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ctc_pkg::ST_IDLE;
            end
        endcase

        if (w_e.req) begin
            w_cnt_new = r_ccnt[w_e.cls];
            if (w_e.bump && w_cnt_new != ctc_pkg::CNT_MAX) w_cnt_new = w_cnt_new + 1'b1;
            n_ccnt[w_e.cls] = w_cnt_new;
            if (w_e.cls == ctc_pkg::CLS_ARITH || w_e.cls == ctc_pkg::CLS_SEMI) begin
                n_op_seen[ctc_pkg::op_bit(w_e.code)] = 1'b1;
            end
            if (w_e.cls == ctc_pkg::CLS_KW) n_kw_seen[w_e.code[4:0]] = 1'b1;
            if (w_e.cls == ctc_pkg::CLS_IDENT && w_e.bump) n_icnt = r_icnt + 1'b1;
            if (r_hold_v) begin
                n_out   = r_hold;
                n_out_v = 1'b1;
            end
            n_hold_v = 1'b1;
            n_hold   = '{token_class: w_e.cls, token_code: w_e.code, const_value: w_e.val,
                         first_seen: w_e.first, class_count: w_cnt_new,
                         overflow: w_e.ovf, last_of_run: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ctc_pkg::ST_IDLE;
            r_used    <= 1'b0;
            r_ret_eol <= 1'b0;
            r_pkind   <= ctc_pkg::PK_NONE;
            r_pop     <= '0;
            r_nlen    <= '0;
            r_acc     <= '0;
            r_spoil   <= 1'b0;
            r_depth   <= '{default: '0};
            r_kw_seen <= '0;
            r_op_seen <= '0;
            r_icnt    <= '0;
            r_ccnt    <= '{default: '0};
            r_res_v   <= 1'b0;
            r_hold_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_ret_eol <= n_ret_eol;
            r_pkind   <= n_pkind;
            r_pop     <= n_pop;
            r_nlen    <= n_nlen;
            r_acc     <= n_acc;
            r_spoil   <= n_spoil;
            r_depth   <= n_depth;
            r_kw_seen <= n_kw_seen;
            r_op_seen <= n_op_seen;
            r_icnt    <= n_icnt;
            r_ccnt    <= n_ccnt;
            r_res_v   <= n_res_v;
            r_hold_v  <= n_hold_v;
            r_out_v   <= n_out_v;
        end
        r_char     <= n_char;
        r_eol      <= n_eol;
        r_nbuf     <= n_nbuf;
        r_res      <= n_res;
        r_res_slot <= n_res_slot;
        r_hold     <= n_hold;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ctc_pkg::ST_IDLE) |-> !r_hold_v)
        else $error("result held while idle");

    a_probe_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pc[MAX_IDENTS].active |-> (r_state == ctc_pkg::ST_SRCH))
        else $error("probe left the chain outside a search");

    a_accept_to_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ctc_pkg::ST_PEND))
        else $error("accepted item not taken to pending stage");

    a_name_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nlen <= LEN_W'(MAX_NAME_LEN + 1))
        else $error("name length beyond limit");

endmodule
